FILE: hw/rtl/fbrf_pkg.sv
package fbrf_pkg;

   localparam int COLOR_W   = 16;
   localparam int COORD_W   = 16;
   localparam int MODE_W    = 2;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int RECT_W    = 3;

   // command codes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd3;

   // rectangle pass order for a framed fill
   localparam logic [RECT_W-1:0] RECT_MAIN   = 3'd0;
   localparam logic [RECT_W-1:0] RECT_LEFT   = 3'd1;
   localparam logic [RECT_W-1:0] RECT_BOTTOM = 3'd2;
   localparam logic [RECT_W-1:0] RECT_RIGHT  = 3'd3;
   localparam logic [RECT_W-1:0] RECT_TOP    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0] MAP_SIZE_RESET = 9'd256;

   typedef struct packed {
      logic [COLOR_W-1:0] edge_color;
      logic [COLOR_W-1:0] fill_color;
      logic [COORD_W-1:0] border_width;
      logic [COORD_W-1:0] row_end;
      logic [COORD_W-1:0] row_start;
      logic [COORD_W-1:0] col_end;
      logic [COORD_W-1:0] col_start;
      logic [MODE_W-1:0]  mode;
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
   } done_type;

   typedef struct packed {
      logic we;
      logic re;
   } mem_ctl_type;

endpackage

FILE: hw/rtl/fbrf_store.sv
module fbrf_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic                        clock,
   input  fbrf_pkg::mem_ctl_type       mem_ctl,
   input  logic [AW-1:0]               mem_addr,
   input  logic [fbrf_pkg::COLOR_W-1:0] mem_wdata,
   output logic [fbrf_pkg::COLOR_W-1:0] mem_rdata
);
   import fbrf_pkg::*;

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

FILE: hw/rtl/fbrf_walk.sv
module fbrf_walk #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int CW    = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + 1),
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  fbrf_pkg::cmd_type            cmd,
   input  logic [CW-1:0]                eff_w,
   input  logic [HW-1:0]                eff_h,
   output fbrf_pkg::done_type           done,
   input  logic                         done_ready,
   output fbrf_pkg::mem_ctl_type        mem_ctl,
   output logic [AW-1:0]                mem_addr,
   output logic [fbrf_pkg::COLOR_W-1:0] mem_wdata,
   input  logic [fbrf_pkg::COLOR_W-1:0] mem_rdata
);
   import fbrf_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BOUNDS = 3'd1;
   localparam logic [2:0] ST_CLIP   = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_RDWAIT = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [RECT_W-1:0]  k_ff, k_in;
   logic [RECT_W-1:0]  last_k_ff, last_k_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COORD_W-1:0] c0_ff, c0_in, c1_ff, c1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [COORD_W-1:0] t_ff, t_in;
   logic [COLOR_W-1:0] fcol_ff, fcol_in, ecol_ff, ecol_in;
   logic [COORD_W-1:0] rc0_ff, rc0_in, rc1_ff, rc1_in, rr0_ff, rr0_in, rr1_ff, rr1_in;
   logic [COLOR_W-1:0] rcolor_ff, rcolor_in;
   logic [XW-1:0]      col_ff, col_in, cstart_ff, cstart_in, cend_ff, cend_in;
   logic [YW-1:0]      row_ff, row_in, rend_ff, rend_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [COLOR_W-1:0] rd_ff, rd_in;

   // shared bound adder
   logic [COORD_W-1:0] add_a, add_res;
   logic               add_sub;
   // clip
   logic [COORD_W-1:0] w16, h16;
   logic               skip;
   logic [YW+CW-1:0]   prod;
   logic               single;

   assign w16    = COORD_W'(eff_w);
   assign h16    = COORD_W'(eff_h);
   assign skip   = (rc1_ff < rc0_ff) || (rr1_ff < rr0_ff) || (rc0_ff >= w16) || (rr0_ff >= h16);
   assign prod   = {{CW{1'b0}}, YW'(rr0_ff)} * {{YW{1'b0}}, eff_w};
   assign single = (mode_ff == MODE_WRITE) || (mode_ff == MODE_READ);

   always_comb begin
      case (k_ff)
         RECT_LEFT:   add_a = c0_ff;
         RECT_BOTTOM: add_a = r1_ff;
         RECT_RIGHT:  add_a = c1_ff;
         RECT_TOP:    add_a = r0_ff;
         default:     add_a = c0_ff;
      endcase
      add_sub = (k_ff == RECT_BOTTOM) || (k_ff == RECT_RIGHT);
      add_res = add_sub ? add_a - t_ff : add_a + t_ff;
   end

   assign mem_addr  = base_ff + AW'(col_ff);
   assign mem_wdata = rcolor_ff;

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      last_k_in = last_k_ff;
      mode_in   = mode_ff;
      c0_in     = c0_ff;
      c1_in     = c1_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      t_in      = t_ff;
      fcol_in   = fcol_ff;
      ecol_in   = ecol_ff;
      rc0_in    = rc0_ff;
      rc1_in    = rc1_ff;
      rr0_in    = rr0_ff;
      rr1_in    = rr1_ff;
      rcolor_in = rcolor_ff;
      col_in    = col_ff;
      cstart_in = cstart_ff;
      cend_in   = cend_ff;
      row_in    = row_ff;
      rend_in   = rend_ff;
      base_in   = base_ff;
      rd_in     = rd_ff;
      cmd_ready = 1'b0;
      mem_ctl   = '0;
      done      = '0;
      done.color = rd_ff;

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               mode_in = cmd.mode;
               c0_in   = cmd.col_start;
               c1_in   = cmd.col_end;
               r0_in   = cmd.row_start;
               r1_in   = cmd.row_end;
               t_in    = cmd.border_width - 16'd1;
               fcol_in = cmd.fill_color;
               ecol_in = cmd.edge_color;
               k_in    = RECT_MAIN;
               rd_in   = '0;
               case (cmd.mode)
                  MODE_FRAME: last_k_in = (cmd.border_width != '0) ? RECT_TOP : RECT_MAIN;
                  MODE_WRITE, MODE_READ, MODE_FILL: last_k_in = RECT_MAIN;
                  default: last_k_in = RECT_MAIN;
               endcase
               state_in = ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            rc0_in    = c0_ff;
            rc1_in    = c1_ff;
            rr0_in    = r0_ff;
            rr1_in    = r1_ff;
            rcolor_in = ecol_ff;
            case (k_ff)
               RECT_MAIN: begin
                  rcolor_in = fcol_ff;
                  if (single) begin
                     rc1_in = c0_ff;
                     rr1_in = r0_ff;
                  end
               end
               RECT_LEFT:   rc1_in = add_res;
               RECT_BOTTOM: rr0_in = add_res;
               RECT_RIGHT:  rc0_in = add_res;
               RECT_TOP:    rr1_in = add_res;
               default:     rcolor_in = fcol_ff;
            endcase
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            if (skip) begin
               if (k_ff == last_k_ff) begin
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_BOUNDS;
               end
            end else begin
               cstart_in = XW'(rc0_ff);
               col_in    = XW'(rc0_ff);
               cend_in   = (rc1_ff >= w16) ? XW'(eff_w - 1'b1) : XW'(rc1_ff);
               row_in    = YW'(rr0_ff);
               rend_in   = (rr1_ff >= h16) ? YW'(eff_h - 1'b1) : YW'(rr1_ff);
               base_in   = AW'(prod);
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (mode_ff == MODE_READ) begin
               mem_ctl.re = 1'b1;
               state_in   = ST_RDWAIT;
            end else begin
               mem_ctl.we = 1'b1;
               if (col_ff == cend_ff) begin
                  col_in = cstart_ff;
                  if (row_ff == rend_ff) begin
                     if (k_ff == last_k_ff) begin
                        state_in = ST_DONE;
                     end else begin
                        k_in     = k_ff + 1'b1;
                        state_in = ST_BOUNDS;
                     end
                  end else begin
                     row_in  = row_ff + 1'b1;
                     base_in = base_ff + AW'(eff_w);
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_RDWAIT: begin
            rd_in    = mem_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done.valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= RECT_MAIN;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      last_k_ff <= last_k_in;
      mode_ff   <= mode_in;
      c0_ff     <= c0_in;
      c1_ff     <= c1_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      t_ff      <= t_in;
      fcol_ff   <= fcol_in;
      ecol_ff   <= ecol_in;
      rc0_ff    <= rc0_in;
      rc1_ff    <= rc1_in;
      rr0_ff    <= rr0_in;
      rr1_ff    <= rr1_in;
      rcolor_ff <= rcolor_in;
      col_ff    <= col_in;
      cstart_ff <= cstart_in;
      cend_ff   <= cend_in;
      row_ff    <= row_in;
      rend_ff   <= rend_in;
      base_ff   <= base_in;
      rd_ff     <= rd_in;
   end

   a_we_re_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.we && mem_ctl.re))
      else $error("store written and read in one cycle");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      (done.valid && mode_ff != MODE_READ) |-> (done.color == '0))
      else $error("non-read command returns a color");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (col_ff <= cend_ff && row_ff <= rend_ff))
      else $error("walk position past clipped rectangle");

   a_rdwait_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDWAIT) |-> $past(mem_ctl.re))
      else $error("read data captured without a read");

endmodule

FILE: hw/rtl/framebuffer_rect_frame_fill.sv
// Framebuffer rectangle blitter: a MAX_WIDTH*MAX_HEIGHT store of 16-bit pixels, pixel
// (col,row) at word row*width+col, with width and height taken from the csr registers
// (values above the parameters act as the parameter). Each req beat is one command and
// gives exactly one rsp beat: write pixel, read pixel (color 0 when clipped), fill
// rectangle, or fill rectangle and overdraw four border strips in edge_color (no strips
// when border_width is 0). All writes clip to the map; a reversed rectangle draws nothing.
// A pixel write steps through the bounds, clip, walk and done states; a read adds a
// read-wait state. Each fill rectangle pass runs a bounds and a clip step, then the walk
// writes one clipped pixel per cycle over the single store write port; a framed fill with
// a border runs five passes (main area, left, bottom, right, top strips). The block takes
// one command at a time; req_tready is high only while the sequencer is idle, and a new
// command may enter while the previous rsp beat is still waiting. The store is not
// cleared: reading a pixel never written returns an undefined value.
module framebuffer_rect_frame_fill #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata, low bit up: mode[1:0], col_start[17:2], col_end[33:18],
   // row_start[49:34], row_end[65:50], border_width[81:66], fill_color[97:82],
   // edge_color[113:98], zero pad[119:114]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [119:0]                   req_tdata,
   // rsp_tdata, low bit up: read_color[15:0], done_res[16], zero pad[23:17]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,
   // csr: index 0 map_width, index 1 map_height
   input  logic                           csr_we,
   input  logic [fbrf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbrf_pkg::CSR_W-1:0]     csr_wdata
);
   import fbrf_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CSR_W-1:0]   map_width_ff, map_width_in;
   logic [CSR_W-1:0]   map_height_ff, map_height_in;
   logic [CW-1:0]      eff_w;
   logic [HW-1:0]      eff_h;

   cmd_type            cmd;
   done_type           done;
   logic               done_ready;
   mem_ctl_type        mem_ctl;
   logic [AW-1:0]      mem_addr;
   logic [COLOR_W-1:0] mem_wdata;
   logic [COLOR_W-1:0] mem_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   // config registers; writes must arrive only while idle, which the block does not enforce
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_wdata;
            CSR_MAP_HEIGHT: map_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp to the physical store
   assign eff_w = (32'(map_width_ff) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(map_width_ff);
   assign eff_h = (32'(map_height_ff) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                         : HW'(map_height_ff);

   // unpack the command beat
   assign cmd.mode         = req_tdata[1:0];
   assign cmd.col_start    = req_tdata[17:2];
   assign cmd.col_end      = req_tdata[33:18];
   assign cmd.row_start    = req_tdata[49:34];
   assign cmd.row_end      = req_tdata[65:50];
   assign cmd.border_width = req_tdata[81:66];
   assign cmd.fill_color   = req_tdata[97:82];
   assign cmd.edge_color   = req_tdata[113:98];

   fbrf_walk #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (req_tready),
      .cmd        (cmd),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .done       (done),
      .done_ready (done_ready),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata)
   );

   fbrf_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // rsp output register: sequencer hands off as soon as the slot frees
   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done.valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = done.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, 1'b1, rsp_color_ff};

endmodule
